[hdl/sfb_pkg.sv]
// sfb_pkg: widths, pipeline geometry, region codes, register indexes and stage
// payload types for the seam feather blend pipeline
// no dependencies
`default_nettype none

package sfb_pkg;

    localparam int COL_W   = 12;
    localparam int PIX_W   = 8;
    localparam int OS_W    = 12;
    localparam int LW_W    = 13;
    localparam int NUM_CH  = 3;
    localparam int NUM_W   = 20;
    localparam int QUO_W   = PIX_W;
    localparam int PA_W    = PIX_W + LW_W;
    localparam int PB_W    = PIX_W + COL_W;

    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
    localparam int NSTAGE         = 3 + DIV_STAGES;

    localparam logic [LW_W-1:0] MAX_WIDTH     = 13'd4096;
    localparam logic [LW_W-1:0] LW_RESET      = 13'd4096;
    localparam logic [OS_W-1:0] OS_RESET      = 12'd0;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_WIDTH    = 8'd1;

    typedef enum logic [1:0] {
        REGION_LEFT  = 2'd0,
        REGION_BLEND = 2'd1,
        REGION_BLACK = 2'd2,
        REGION_WARP  = 2'd3
    } region_t;

    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] p;
        logic [NUM_CH-1:0][PIX_W-1:0] t;
        logic [LW_W-1:0]              wmk;
        logic [COL_W-1:0]             k;
        logic [LW_W-1:0]              w;
        region_t                      region;
    } s1_t;

    typedef struct packed {
        logic [NUM_CH-1:0][PA_W-1:0] prod_a;
        logic [NUM_CH-1:0][PB_W-1:0] prod_b;
        logic [LW_W-1:0]             w;
        region_t                     region;
    } s2_t;

    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] num;
        logic [LW_W-1:0]              w;
        region_t                      region;
    } s3_t;

    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] rem;
        logic [NUM_CH-1:0][QUO_W-1:0] quo;
        logic [LW_W-1:0]              w;
        region_t                      region;
    } div_t;

endpackage

`default_nettype wire

[hdl/seam_feather_blend.sv]
// seam_feather_blend: top level of the panorama seam feather blend pipeline
// depends on sfb_pkg
//
// usage
//   s_axis carries one pixel pair per transaction: column, left rgb, warped rgb
//   m_axis returns one composed rgb pixel per input transaction, with its
//   region code in tuser (left only, blended, black warp passthrough, warp only)
//   cfg writes overlap_start (index 0) and left_width (index 1); cfg_ready is
//   always high, other indexes are dropped; write only while the pipe is empty
//   throughput is one pixel per clock; latency is 7 register stages, so output
//   valid follows the input transaction by 6 cycles: decode, weight multiply,
//   sum, then four divider stages that each resolve two quotient bits per channel
//   each stage holds a valid bit and moves only when the next one is free or
//   moving, so a stalled receiver fills the bubbles first and then drops
//   s_axis_tready; nothing is lost or repeated
//   reset empties the pipe and loads overlap_start 0 and left_width 4096
`default_nettype none

module seam_feather_blend
    import sfb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // column, left_red, left_green, left_blue, warp_red, warp_green, warp_blue
    input  wire logic [63:0]          s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]               m_axis_tdata,
    // region
    output logic [1:0]                m_axis_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LW_W-1:0]      cfg_data
);

    logic [OS_W-1:0]   os_reg;
    logic [LW_W-1:0]   lw_reg;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    div_t div_reg  [DIV_STAGES];
    div_t div_in   [DIV_STAGES];
    div_t div_next [DIV_STAGES];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            os_reg <= OS_RESET;
            lw_reg <= LW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OVERLAP_START: os_reg <= cfg_data[OS_W-1:0];
                CFG_LEFT_WIDTH:    lw_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // stage enables, bubbles collapse under stall
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_axis_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 1: region decode and weights
    always_comb
    begin
        logic [LW_W-1:0]  lw_eff;
        logic [LW_W-1:0]  col;
        logic [COL_W-1:0] col_in;
        logic             black;
        lw_eff = (lw_reg > MAX_WIDTH) ? MAX_WIDTH : lw_reg;
        col_in = s_axis_tdata[COL_W-1:0];
        col    = {1'b0, col_in};
        for (int c = 0; c < NUM_CH; c++)
        begin
            s1_next.p[c] = s_axis_tdata[COL_W + c*PIX_W +: PIX_W];
            s1_next.t[c] = s_axis_tdata[COL_W + (NUM_CH + c)*PIX_W +: PIX_W];
        end
        black = (s1_next.t == '0);
        // passthrough cases divide by one with a unit weight on one side
        s1_next.w   = LW_W'(1);
        s1_next.wmk = LW_W'(1);
        s1_next.k   = '0;
        if (col >= lw_eff)
        begin
            s1_next.region = REGION_WARP;
            s1_next.wmk    = '0;
            s1_next.k      = COL_W'(1);
        end
        else if (col_in < os_reg)
        begin
            s1_next.region = REGION_LEFT;
        end
        else if (black)
        begin
            s1_next.region = REGION_BLACK;
        end
        else
        begin
            s1_next.region = REGION_BLEND;
            s1_next.w      = lw_eff - {1'b0, os_reg};
            s1_next.wmk    = lw_eff - col;
            s1_next.k      = col_in - os_reg;
        end
    end

    // stage 2: weight products
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            s2_next.prod_a[c] = s1_reg.p[c] * s1_reg.wmk;
            s2_next.prod_b[c] = s1_reg.t[c] * s1_reg.k;
        end
        s2_next.w      = s1_reg.w;
        s2_next.region = s1_reg.region;
    end

    // stage 3: numerator
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            s3_next.num[c] = NUM_W'(s2_reg.prod_a[c] + PA_W'(s2_reg.prod_b[c]));
        end
        s3_next.w      = s2_reg.w;
        s3_next.region = s2_reg.region;
    end

    // restoring divider, two quotient bits per stage
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            always_comb
            begin
                div_in[j].rem    = s3_reg.num;
                div_in[j].quo    = '0;
                div_in[j].w      = s3_reg.w;
                div_in[j].region = s3_reg.region;
            end
        end
        else
        begin : g_rest
            assign div_in[j] = div_reg[j-1];
        end

        always_comb
        begin
            logic [NUM_W:0] dvs;
            div_next[j] = div_in[j];
            for (int c = 0; c < NUM_CH; c++)
            begin
                for (int b = 0; b < BITS_PER_STAGE; b++)
                begin
                    dvs = {{(NUM_W + 1 - LW_W){1'b0}}, div_in[j].w}
                          << (QUO_W - 1 - j*BITS_PER_STAGE - b);
                    if ({1'b0, div_next[j].rem[c]} >= dvs)
                    begin
                        div_next[j].rem[c] = div_next[j].rem[c] - dvs[NUM_W-1:0];
                        div_next[j].quo[c][QUO_W - 1 - j*BITS_PER_STAGE - b] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[3+j])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
    end

    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = div_reg[DIV_STAGES-1].quo;
    assign m_axis_tuser  = div_reg[DIV_STAGES-1].region;

endmodule

`default_nettype wire

[hdl/sfb_checker.sv]
// sfb_checker: port-level assertions for seam_feather_blend, with its bind
// depends on the seam_feather_blend port list only
`default_nettype none

module sfb_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        cfg_ready
);

    // pipe is empty while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // stalled output transaction holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    // a free or draining output lets every stage move
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is free");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind seam_feather_blend sfb_checker u_sfb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

[dv/seam_feather_blend_test.sv]
// seam_feather_blend_test: self-checking stream testbench for the seam feather blend,
// predicting each composed pixel and its region from the register settings and pixel pair
// depends on sfb_pkg and seam_feather_blend
`default_nettype none

module seam_feather_blend_test;
    import sfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 160;
    localparam int NUM_PHASES     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hA5;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] left_red;
        logic [PIX_W-1:0] left_green;
        logic [PIX_W-1:0] left_blue;
        logic [PIX_W-1:0] warp_red;
        logic [PIX_W-1:0] warp_green;
        logic [PIX_W-1:0] warp_blue;
    } pixel_pair_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        region_t          region;
    } seam_pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LW_W-1:0]      cfg_data = '0;

    logic [OS_W-1:0] mdl_overlap_start = OS_RESET;
    logic [LW_W-1:0] mdl_left_width = LW_RESET;

    pixel_pair_t pending_pairs[$];
    seam_pixel_t expected_pixels[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_grant = 0;
    int hold_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    seam_feather_blend i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned feather(input int unsigned p, input int unsigned t,
                                            input int unsigned w, input int unsigned k);
        return (p * (w - k) + t * k) / w;
    endfunction

    function automatic seam_pixel_t compose_pixel(input pixel_pair_t px);
        seam_pixel_t res;
        int unsigned lw_eff;
        int unsigned os;
        int unsigned col;
        lw_eff = (mdl_left_width > MAX_WIDTH) ? MAX_WIDTH : mdl_left_width;
        os = mdl_overlap_start;
        col = px.column;
        if (col >= lw_eff)
        begin
            res = '{px.warp_red, px.warp_green, px.warp_blue, REGION_WARP};
        end
        else if (col < os)
        begin
            res = '{px.left_red, px.left_green, px.left_blue, REGION_LEFT};
        end
        else if (px.warp_red == 0 && px.warp_green == 0 && px.warp_blue == 0)
        begin
            res = '{px.left_red, px.left_green, px.left_blue, REGION_BLACK};
        end
        else
        begin
            res.red    = PIX_W'(feather(px.left_red, px.warp_red, lw_eff - os, col - os));
            res.green  = PIX_W'(feather(px.left_green, px.warp_green, lw_eff - os, col - os));
            res.blue   = PIX_W'(feather(px.left_blue, px.warp_blue, lw_eff - os, col - os));
            res.region = REGION_BLEND;
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] random_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t px;
        int unsigned lw_eff;
        int edge_col;
        lw_eff = (mdl_left_width > MAX_WIDTH) ? MAX_WIDTH : mdl_left_width;
        case ($urandom_range(3))
            0, 1:
            begin
                if (mdl_overlap_start < lw_eff)
                    px.column = COL_W'($urandom_range(lw_eff - 1, mdl_overlap_start));
                else
                    px.column = COL_W'($urandom_range(4095));
            end
            2:
            begin
                case ($urandom_range(5))
                    0: edge_col = int'(mdl_overlap_start) - 1;
                    1: edge_col = int'(mdl_overlap_start);
                    2: edge_col = int'(lw_eff) - 1;
                    3: edge_col = int'(lw_eff);
                    4: edge_col = 0;
                    default: edge_col = 4095;
                endcase
                px.column = edge_col[COL_W-1:0];
            end
            default: px.column = COL_W'($urandom_range(4095));
        endcase
        px.left_red   = random_channel();
        px.left_green = random_channel();
        px.left_blue  = random_channel();
        if ($urandom_range(5) == 0)
        begin
            px.warp_red   = '0;
            px.warp_green = '0;
            px.warp_blue  = '0;
        end
        else
        begin
            px.warp_red   = random_channel();
            px.warp_green = random_channel();
            px.warp_blue  = random_channel();
        end
        return px;
    endfunction

    // driver: holds an offered transaction until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels = {expected_pixels, compose_pixel(pending_pairs.pop_front())};
            if (s_axis_tvalid && !s_axis_tready)
            begin
            end
            else if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, pending_pairs[0].warp_blue, pending_pairs[0].warp_green,
                                  pending_pairs[0].warp_red, pending_pairs[0].left_blue,
                                  pending_pairs[0].left_green, pending_pairs[0].left_red,
                                  pending_pairs[0].column};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        seam_pixel_t exp_px;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("output transaction with no pixel expected");
                    mismatches++;
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (m_axis_tdata[7:0] !== exp_px.red)
                    begin
                        $error("out_red expected %0d got %0d", exp_px.red, m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[15:8] !== exp_px.green)
                    begin
                        $error("out_green expected %0d got %0d", exp_px.green,
                               m_axis_tdata[15:8]);
                        mismatches++;
                    end
                    if (m_axis_tdata[23:16] !== exp_px.blue)
                    begin
                        $error("out_blue expected %0d got %0d", exp_px.blue,
                               m_axis_tdata[23:16]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== exp_px.region)
                    begin
                        $error("region expected %0d got %0d", exp_px.region, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (hold_grant != hold_request)
            begin
                hold_grant = hold_request;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LW_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OVERLAP_START)
            mdl_overlap_start = value[OS_W-1:0];
        else if (idx == CFG_LEFT_WIDTH)
            mdl_left_width = value;
    endtask

    task automatic queue_pair(input logic [COL_W-1:0] col, input logic [PIX_W-1:0] lr,
                              input logic [PIX_W-1:0] lg, input logic [PIX_W-1:0] lb,
                              input logic [PIX_W-1:0] wr, input logic [PIX_W-1:0] wg,
                              input logic [PIX_W-1:0] wb);
        @(negedge clk);
        pending_pairs = {pending_pairs, pixel_pair_t'{col, lr, lg, lb, wr, wg, wb}};
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            @(negedge clk);
            pending_pairs = {pending_pairs, random_pair()};
        end
    endtask

    // sender pause: wait until every queued pixel has come back
    task automatic drain();
        @(negedge clk);
        while (pending_pairs.size() != 0 || expected_pixels.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [OS_W:0]   os_tab[NUM_PHASES];
        logic [LW_W-1:0] lw_tab[NUM_PHASES];
        int mode;
        rst_n <= 1'b0;
        // overlap start with its top data bit set checks the register is 12 bits wide
        os_tab = '{13'd1000, 13'd4095, 13'd0, 13'd100, 13'd3000, 13'd2000, 13'h1800, 13'd0};
        lw_tab = '{13'd1256, 13'd4096, 13'd1, 13'd0, 13'd8191, 13'd1500, 13'd2100, 13'd4096};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: the whole row is one overlap
        queue_pair(12'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        queue_pair(12'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd255, 8'd0);
        queue_pair(12'd4095, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        queue_pair(12'd4095, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_pair(12'd2048, 8'd200, 8'd17, 8'd99, 8'd3, 8'd250, 8'd128);
        queue_pair(12'd2048, 8'd10, 8'd20, 8'd30, 8'd0, 8'd0, 8'd0);
        drain();

        write_reg(CFG_OVERLAP_START, 13'd1000);
        write_reg(CFG_LEFT_WIDTH, 13'd1256);
        queue_pair(12'd999, 8'd255, 8'd128, 8'd0, 8'd77, 8'd66, 8'd55);
        queue_pair(12'd1000, 8'd255, 8'd128, 8'd0, 8'd77, 8'd66, 8'd55);
        queue_pair(12'd1128, 8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3);
        queue_pair(12'd1255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        queue_pair(12'd1256, 8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66);
        queue_pair(12'd1100, 8'd90, 8'd91, 8'd92, 8'd0, 8'd0, 8'd0);
        queue_pair(12'd500, 8'd90, 8'd91, 8'd92, 8'd0, 8'd0, 8'd0);
        queue_pair(12'd2000, 8'd90, 8'd91, 8'd92, 8'd0, 8'd0, 8'd0);
        queue_pair(12'd1100, 8'd50, 8'd60, 8'd70, 8'd0, 8'd0, 8'd1);
        queue_pair(12'd4095, 8'd1, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            mode = p % 4;
            if (p == 3)
                write_reg(CFG_UNMAPPED, LW_W'($urandom_range(8191)));
            write_reg(CFG_OVERLAP_START, os_tab[p][LW_W-1:0]);
            write_reg(CFG_LEFT_WIDTH, lw_tab[p]);
            if (p == 5)
                write_reg(CFG_IDX_W'($urandom_range(255, CFG_LEFT_WIDTH + 1)),
                          LW_W'($urandom_range(8191)));
            @(negedge clk);
            send_idle_pct  = (mode == 1) ? 74 : (mode == 3) ? 27 : 0;
            recv_stall_pct = (mode == 2) ? 74 : (mode == 3) ? 27 : 0;
            if (p == 2)
            begin
                // long receiver hold-off while the sender keeps offering
                hold_request++;
                queue_random(60);
                queue_random(PHASE_ITEMS - 60);
            end
            else
            begin
                queue_random(PHASE_ITEMS);
            end
            drain();
        end

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
